// ===== rtl/core/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths, register indexes, pipeline types and step functions for the
// quaternion vector rotate core.
// ----------------------------------------------------------------------------
package qvr_pkg;

    localparam int Q_W       = 16;   // quaternion and vector components
    localparam int CFG_IDX_W = 8;
    localparam int PRD_W     = 32;   // quaternion component products
    localparam int M_W       = 35;   // rotation matrix entries, Q28
    localparam int P_W       = 51;   // matrix entry times vector component
    localparam int R_W       = 53;   // rotated vector component
    localparam int MAG_W     = 52;   // magnitude of a rotated component
    localparam int SH_W      = 5;    // normalizing shift
    localparam int C_W       = 31;   // shifted magnitude
    localparam int SQ_W      = 62;
    localparam int SUM_W     = 64;
    localparam int LEN_W     = 32;
    localparam int NUM_W     = 46;   // rounded dividend
    localparam int DEN_W     = 47;   // shifted divisor
    localparam int QT_W      = 15;   // quotient
    localparam int FRAC_W    = 14;
    localparam int SQRT_STEPS = SUM_W / 2;
    localparam int DIV_STEPS  = QT_W;

    localparam logic signed [M_W-1:0] ONE_Q28 = M_W'(64'sd268435456);
    localparam logic [QT_W-1:0]       OUT_ONE = QT_W'(16384);

    localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = CFG_IDX_W'(3);

    // direction info that travels with the length computation
    typedef struct packed {
        logic [2:0]            neg;
        logic                  zero;
        logic [2:0][C_W-1:0]   c;
    } dir_t;

    typedef struct packed {
        logic [SUM_W-1:0] n;
        logic [SUM_W-1:0] res;
    } sqrt_state_t;

    // one digit of the bitwise integer square root
    function automatic sqrt_state_t sqrt_step(input sqrt_state_t st,
                                              input logic [SUM_W-1:0] bitv);
        sqrt_state_t nx;
        logic [SUM_W-1:0] trial;
        trial = st.res + bitv;
        if (st.n >= trial)
        begin
            nx.n   = st.n - trial;
            nx.res = (st.res >> 1) + bitv;
        end
        else
        begin
            nx.n   = st.n;
            nx.res = st.res >> 1;
        end
        return nx;
    endfunction

    // right shift that brings the largest magnitude below 2^31
    function automatic logic [SH_W-1:0] lead_shift(input logic [MAG_W-1:0] a);
        logic [SH_W-1:0] sh;
        sh = '0;
        for (int i = C_W; i < MAG_W; i++)
        begin
            if (a[i])
                sh = SH_W'(i - C_W + 1);
        end
        return sh;
    endfunction

endpackage

// ===== rtl/core/qvr_rotate.sv =====
// ----------------------------------------------------------------------------
// qvr_rotate
// Four stages: quaternion products, Q28 rotation matrix, matrix-vector
// products and row sums.
// ----------------------------------------------------------------------------
module qvr_rotate (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [qvr_pkg::Q_W-1:0]     quat_w,
    input  logic signed [qvr_pkg::Q_W-1:0]     quat_x,
    input  logic signed [qvr_pkg::Q_W-1:0]     quat_y,
    input  logic signed [qvr_pkg::Q_W-1:0]     quat_z,
    input  logic signed [qvr_pkg::Q_W-1:0]     vec_x,
    input  logic signed [qvr_pkg::Q_W-1:0]     vec_y,
    input  logic signed [qvr_pkg::Q_W-1:0]     vec_z,
    output logic                               r_valid,
    output logic signed [qvr_pkg::R_W-1:0]     r [3]
);

    logic [3:0] valid_reg;

    logic signed [qvr_pkg::Q_W-1:0]   v1_reg [3];
    logic signed [qvr_pkg::Q_W-1:0]   v2_reg [3];
    logic signed [qvr_pkg::PRD_W-1:0] xx_reg, yy_reg, zz_reg;
    logic signed [qvr_pkg::PRD_W-1:0] xy_reg, xz_reg, yz_reg;
    logic signed [qvr_pkg::PRD_W-1:0] xw_reg, yw_reg, zw_reg;
    logic signed [qvr_pkg::M_W-1:0]   m_reg [3][3];
    logic signed [qvr_pkg::P_W-1:0]   p_reg [3][3];
    logic signed [qvr_pkg::R_W-1:0]   r_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg[0] <= vec_x;
            v1_reg[1] <= vec_y;
            v1_reg[2] <= vec_z;
            xx_reg <= qvr_pkg::PRD_W'(quat_x) * qvr_pkg::PRD_W'(quat_x);
            yy_reg <= qvr_pkg::PRD_W'(quat_y) * qvr_pkg::PRD_W'(quat_y);
            zz_reg <= qvr_pkg::PRD_W'(quat_z) * qvr_pkg::PRD_W'(quat_z);
            xy_reg <= qvr_pkg::PRD_W'(quat_x) * qvr_pkg::PRD_W'(quat_y);
            xz_reg <= qvr_pkg::PRD_W'(quat_x) * qvr_pkg::PRD_W'(quat_z);
            yz_reg <= qvr_pkg::PRD_W'(quat_y) * qvr_pkg::PRD_W'(quat_z);
            xw_reg <= qvr_pkg::PRD_W'(quat_x) * qvr_pkg::PRD_W'(quat_w);
            yw_reg <= qvr_pkg::PRD_W'(quat_y) * qvr_pkg::PRD_W'(quat_w);
            zw_reg <= qvr_pkg::PRD_W'(quat_z) * qvr_pkg::PRD_W'(quat_w);

            v2_reg <= v1_reg;
            m_reg[0][0] <= qvr_pkg::ONE_Q28
                - ((qvr_pkg::M_W'(yy_reg) + qvr_pkg::M_W'(zz_reg)) <<< 1);
            m_reg[0][1] <= (qvr_pkg::M_W'(xy_reg) - qvr_pkg::M_W'(zw_reg)) <<< 1;
            m_reg[0][2] <= (qvr_pkg::M_W'(xz_reg) + qvr_pkg::M_W'(yw_reg)) <<< 1;
            m_reg[1][0] <= (qvr_pkg::M_W'(xy_reg) + qvr_pkg::M_W'(zw_reg)) <<< 1;
            m_reg[1][1] <= qvr_pkg::ONE_Q28
                - ((qvr_pkg::M_W'(xx_reg) + qvr_pkg::M_W'(zz_reg)) <<< 1);
            m_reg[1][2] <= (qvr_pkg::M_W'(yz_reg) - qvr_pkg::M_W'(xw_reg)) <<< 1;
            m_reg[2][0] <= (qvr_pkg::M_W'(xz_reg) - qvr_pkg::M_W'(yw_reg)) <<< 1;
            m_reg[2][1] <= (qvr_pkg::M_W'(yz_reg) + qvr_pkg::M_W'(xw_reg)) <<< 1;
            m_reg[2][2] <= qvr_pkg::ONE_Q28
                - ((qvr_pkg::M_W'(xx_reg) + qvr_pkg::M_W'(yy_reg)) <<< 1);

            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                    p_reg[i][j] <= qvr_pkg::P_W'(m_reg[i][j]) * qvr_pkg::P_W'(v2_reg[j]);
                r_reg[i] <= qvr_pkg::R_W'(p_reg[i][0]) + qvr_pkg::R_W'(p_reg[i][1])
                          + qvr_pkg::R_W'(p_reg[i][2]);
            end
        end
    end

    assign r_valid = valid_reg[3];
    assign r       = r_reg;

endmodule

// ===== rtl/core/qvr_scale.sv =====
// ----------------------------------------------------------------------------
// qvr_scale
// Six stages: magnitudes, largest magnitude, normalizing shift, shifted
// magnitudes, squares and sum of squares.
// ----------------------------------------------------------------------------
module qvr_scale (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               r_valid,
    input  logic signed [qvr_pkg::R_W-1:0]     r [3],
    output logic                               s_valid,
    output qvr_pkg::dir_t                      dir,
    output logic [qvr_pkg::SUM_W-1:0]          sum
);

    logic [5:0] valid_reg;

    logic [2:0] neg_reg [6];
    logic       zero_reg [6];
    logic [qvr_pkg::MAG_W-1:0] mag5_reg [3];
    logic [qvr_pkg::MAG_W-1:0] mag6_reg [3];
    logic [qvr_pkg::MAG_W-1:0] mag7_reg [3];
    logic [qvr_pkg::MAG_W-1:0] max6_reg;
    logic [qvr_pkg::SH_W-1:0]  sh7_reg;
    logic [qvr_pkg::C_W-1:0]   c8_reg [3];
    logic [qvr_pkg::C_W-1:0]   c9_reg [3];
    logic [qvr_pkg::C_W-1:0]   c10_reg [3];
    logic [qvr_pkg::SQ_W-1:0]  sq9_reg [3];
    logic [qvr_pkg::SUM_W-1:0] sum10_reg;
    logic [qvr_pkg::MAG_W-1:0] max01;

    assign max01 = (mag5_reg[1] > mag5_reg[0]) ? mag5_reg[1] : mag5_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[4:0], r_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0]  <= {r[2][qvr_pkg::R_W-1], r[1][qvr_pkg::R_W-1], r[0][qvr_pkg::R_W-1]};
            zero_reg[0] <= (r[0] == '0) && (r[1] == '0) && (r[2] == '0);
            for (int i = 0; i < 3; i++)
                mag5_reg[i] <= r[i][qvr_pkg::R_W-1] ? qvr_pkg::MAG_W'(-r[i])
                                                     : qvr_pkg::MAG_W'(r[i]);
            for (int k = 1; k < 6; k++)
            begin
                neg_reg[k]  <= neg_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end

            mag6_reg <= mag5_reg;
            max6_reg <= (mag5_reg[2] > max01) ? mag5_reg[2] : max01;

            mag7_reg <= mag6_reg;
            sh7_reg  <= qvr_pkg::lead_shift(max6_reg);

            for (int i = 0; i < 3; i++)
            begin
                c8_reg[i]  <= qvr_pkg::C_W'(mag7_reg[i] >> sh7_reg);
                sq9_reg[i] <= qvr_pkg::SQ_W'(c8_reg[i]) * qvr_pkg::SQ_W'(c8_reg[i]);
            end
            c9_reg  <= c8_reg;
            c10_reg <= c9_reg;
            sum10_reg <= qvr_pkg::SUM_W'(sq9_reg[0]) + qvr_pkg::SUM_W'(sq9_reg[1])
                       + qvr_pkg::SUM_W'(sq9_reg[2]);
        end
    end

    assign s_valid  = valid_reg[5];
    assign dir.neg  = neg_reg[5];
    assign dir.zero = zero_reg[5];
    assign dir.c    = {c10_reg[2], c10_reg[1], c10_reg[0]};
    assign sum      = sum10_reg;

endmodule

// ===== rtl/core/qvr_sqrt.sv =====
// ----------------------------------------------------------------------------
// qvr_sqrt
// Integer square root of the sum of squares, one result bit per stage.
// ----------------------------------------------------------------------------
module qvr_sqrt (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               s_valid,
    input  qvr_pkg::dir_t                      dir,
    input  logic [qvr_pkg::SUM_W-1:0]          sum,
    output logic                               l_valid,
    output qvr_pkg::dir_t                      l_dir,
    output logic [qvr_pkg::LEN_W-1:0]          len
);

    logic [qvr_pkg::SQRT_STEPS-1:0] valid_reg;
    qvr_pkg::sqrt_state_t           st_reg  [qvr_pkg::SQRT_STEPS];
    qvr_pkg::dir_t                  dir_reg [qvr_pkg::SQRT_STEPS];
    qvr_pkg::sqrt_state_t           st_in;

    assign st_in.n   = sum;
    assign st_in.res = '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[qvr_pkg::SQRT_STEPS-2:0], s_valid};
    end

    for (genvar k = 0; k < qvr_pkg::SQRT_STEPS; k++)
    begin : g_step
        localparam logic [qvr_pkg::SUM_W-1:0] BitV =
            qvr_pkg::SUM_W'(1) << (qvr_pkg::SUM_W - 2 - 2 * k);
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    st_reg[k]  <= qvr_pkg::sqrt_step(st_in, BitV);
                    dir_reg[k] <= dir;
                end
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    st_reg[k]  <= qvr_pkg::sqrt_step(st_reg[k-1], BitV);
                    dir_reg[k] <= dir_reg[k-1];
                end
            end
        end
    end

    assign l_valid = valid_reg[qvr_pkg::SQRT_STEPS-1];
    assign l_dir   = dir_reg[qvr_pkg::SQRT_STEPS-1];
    assign len     = qvr_pkg::LEN_W'(st_reg[qvr_pkg::SQRT_STEPS-1].res);

endmodule

// ===== rtl/core/qvr_div.sv =====
// ----------------------------------------------------------------------------
// qvr_div
// Rounded divide of each magnitude by the length, one quotient bit per
// stage for all three components, then clamp, sign and output register.
// ----------------------------------------------------------------------------
module qvr_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               l_valid,
    input  qvr_pkg::dir_t                      l_dir,
    input  logic [qvr_pkg::LEN_W-1:0]          len,
    output logic                               out_valid,
    output logic signed [qvr_pkg::Q_W-1:0]     out_x,
    output logic signed [qvr_pkg::Q_W-1:0]     out_y,
    output logic signed [qvr_pkg::Q_W-1:0]     out_z,
    output logic                               zero_length
);

    localparam int NStg = qvr_pkg::DIV_STEPS + 1;

    logic [NStg:0]                    valid_reg;
    logic [qvr_pkg::LEN_W-1:0]        den_reg [NStg];
    logic [qvr_pkg::NUM_W-1:0]        rem_reg [NStg][3];
    logic [qvr_pkg::QT_W-1:0]         quo_reg [NStg][3];
    logic [2:0]                       neg_reg [NStg];
    logic                             zero_reg [NStg];
    logic signed [qvr_pkg::Q_W-1:0]   o_reg [3];
    logic                             zl_reg;
    logic [qvr_pkg::LEN_W-1:0]        len_safe;

    assign len_safe = (len == '0) ? qvr_pkg::LEN_W'(1) : len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[NStg-1:0], l_valid};
    end

    // setup: dividend c * 2^14 + len / 2
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0]  <= len_safe;
            neg_reg[0]  <= l_dir.neg;
            zero_reg[0] <= l_dir.zero;
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[0][i] <= (qvr_pkg::NUM_W'(l_dir.c[i]) << qvr_pkg::FRAC_W)
                               + qvr_pkg::NUM_W'(len_safe >> 1);
                quo_reg[0][i] <= '0;
            end
        end
    end

    for (genvar k = 1; k < NStg; k++)
    begin : g_step
        localparam int Sh = qvr_pkg::QT_W - k;
        logic [qvr_pkg::DEN_W-1:0] dsh;
        assign dsh = qvr_pkg::DEN_W'(den_reg[k-1]) << Sh;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[k]  <= den_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    if (qvr_pkg::DEN_W'(rem_reg[k-1][i]) >= dsh)
                    begin
                        rem_reg[k][i] <= qvr_pkg::NUM_W'(qvr_pkg::DEN_W'(rem_reg[k-1][i]) - dsh);
                        quo_reg[k][i] <= quo_reg[k-1][i] | (qvr_pkg::QT_W'(1) << Sh);
                    end
                    else
                    begin
                        rem_reg[k][i] <= rem_reg[k-1][i];
                        quo_reg[k][i] <= quo_reg[k-1][i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zl_reg <= zero_reg[NStg-1];
            for (int i = 0; i < 3; i++)
            begin
                logic [qvr_pkg::QT_W-1:0] qc;
                qc = (quo_reg[NStg-1][i] > qvr_pkg::OUT_ONE) ? qvr_pkg::OUT_ONE
                                                             : quo_reg[NStg-1][i];
                if (zero_reg[NStg-1])
                    o_reg[i] <= '0;
                else if (neg_reg[NStg-1][i])
                    o_reg[i] <= -qvr_pkg::Q_W'(qc);
                else
                    o_reg[i] <= qvr_pkg::Q_W'(qc);
            end
        end
    end

    assign out_valid   = valid_reg[NStg];
    assign out_x       = o_reg[0];
    assign out_y       = o_reg[1];
    assign out_z       = o_reg[2];
    assign zero_length = zl_reg;

endmodule

// ===== rtl/core/quaternion_vector_rotate_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_core
// Rotates each input vector by the configured quaternion and emits the
// unit-length result in Q2.14.
//
//   channel  signals                                   direction
//   in       in_valid in_ready vec_x vec_y vec_z       request in
//   out      out_valid out_ready out_x out_y out_z     request out
//            zero_length
//   cfg      cfg_valid cfg_ready cfg_index cfg_data    register write in
//
// One request enters per cycle while the pipeline advances; each result passes
// through 4 rotate, 6 scale, 32 square-root and 17 divide stages.
// The whole pipeline advances together; it holds only while the output
// register is full and out_ready is low.
// Reset clears all valid bits and loads the identity quaternion.
// Configuration writes are always taken and must come with no request in
// flight.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [qvr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [qvr_pkg::Q_W-1:0]               cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [qvr_pkg::Q_W-1:0]        vec_x,
    input  logic signed [qvr_pkg::Q_W-1:0]        vec_y,
    input  logic signed [qvr_pkg::Q_W-1:0]        vec_z,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [qvr_pkg::Q_W-1:0]        out_x,
    output logic signed [qvr_pkg::Q_W-1:0]        out_y,
    output logic signed [qvr_pkg::Q_W-1:0]        out_z,
    output logic                                  zero_length
);

    logic signed [qvr_pkg::Q_W-1:0] quat_w_reg, quat_x_reg, quat_y_reg, quat_z_reg;
    logic                           en;
    logic                           r_valid, s_valid, l_valid;
    logic signed [qvr_pkg::R_W-1:0] r [3];
    qvr_pkg::dir_t                  s_dir, l_dir;
    logic [qvr_pkg::SUM_W-1:0]      sum;
    logic [qvr_pkg::LEN_W-1:0]      len;

    assign cfg_ready = 1'b1;
    assign en        = !out_valid || out_ready;
    assign in_ready  = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_w_reg <= qvr_pkg::Q_W'(16384);
            quat_x_reg <= '0;
            quat_y_reg <= '0;
            quat_z_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                qvr_pkg::REG_QUAT_W: quat_w_reg <= cfg_data;
                qvr_pkg::REG_QUAT_X: quat_x_reg <= cfg_data;
                qvr_pkg::REG_QUAT_Y: quat_y_reg <= cfg_data;
                qvr_pkg::REG_QUAT_Z: quat_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    qvr_rotate u_rotate (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .quat_w   (quat_w_reg),
        .quat_x   (quat_x_reg),
        .quat_y   (quat_y_reg),
        .quat_z   (quat_z_reg),
        .vec_x    (vec_x),
        .vec_y    (vec_y),
        .vec_z    (vec_z),
        .r_valid  (r_valid),
        .r        (r)
    );

    qvr_scale u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .r_valid (r_valid),
        .r       (r),
        .s_valid (s_valid),
        .dir     (s_dir),
        .sum     (sum)
    );

    qvr_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .s_valid (s_valid),
        .dir     (s_dir),
        .sum     (sum),
        .l_valid (l_valid),
        .l_dir   (l_dir),
        .len     (len)
    );

    qvr_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .l_valid     (l_valid),
        .l_dir       (l_dir),
        .len         (len),
        .out_valid   (out_valid),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .zero_length (zero_length)
    );

    // a zero-length result carries all-zero components
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_length |-> out_x == '0 && out_y == '0 && out_z == '0)
        else $error("zero_length result with nonzero components");

    // components stay within unit range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_x >= -16'sd16384 && out_x <= 16'sd16384
                   && out_y >= -16'sd16384 && out_y <= 16'sd16384
                   && out_z >= -16'sd16384 && out_z <= 16'sd16384)
        else $error("result component out of unit range");

    // an empty output register never holds back the input
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // a nonzero result has at least one nonzero component
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !zero_length |-> out_x != '0 || out_y != '0 || out_z != '0)
        else $error("nonzero result with all-zero components");

endmodule

// ===== bench/qvr_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qvr_checker
// Watches the config, request and result channels of the quaternion vector
// rotate core, predicts each unit vector and compares it with the result.
// ----------------------------------------------------------------------------
module qvr_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [qvr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [qvr_pkg::Q_W-1:0]           cfg_data,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic signed [qvr_pkg::Q_W-1:0]    vec_x,
    input  logic signed [qvr_pkg::Q_W-1:0]    vec_y,
    input  logic signed [qvr_pkg::Q_W-1:0]    vec_z,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic signed [qvr_pkg::Q_W-1:0]    out_x,
    input  logic signed [qvr_pkg::Q_W-1:0]    out_y,
    input  logic signed [qvr_pkg::Q_W-1:0]    out_z,
    input  logic                              zero_length,
    output int                                fail_count,
    output int                                pending
);

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               zl;
    } unit_vec_t;

    logic signed [15:0] q_w, q_x, q_y, q_z;
    unit_vec_t          unit_queue[$];

    assign pending = unit_queue.size();

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic unit_vec_t rotate_unit(input logic signed [15:0] vx,
                                              input logic signed [15:0] vy,
                                              input logic signed [15:0] vz);
        longint w, x, y, z;
        longint m[3][3];
        longint v[3];
        longint r[3];
        longint unsigned c[3];
        longint unsigned a, sum, len, q;
        int s;
        logic signed [15:0] o[3];
        unit_vec_t u;
        w = q_w; x = q_x; y = q_y; z = q_z;
        m[0][0] = 64'sd268435456 - 2 * (y*y + z*z);
        m[0][1] = 2 * (x*y - z*w);
        m[0][2] = 2 * (x*z + y*w);
        m[1][0] = 2 * (x*y + z*w);
        m[1][1] = 64'sd268435456 - 2 * (x*x + z*z);
        m[1][2] = 2 * (y*z - x*w);
        m[2][0] = 2 * (x*z - y*w);
        m[2][1] = 2 * (y*z + x*w);
        m[2][2] = 64'sd268435456 - 2 * (x*x + y*y);
        v[0] = vx; v[1] = vy; v[2] = vz;
        for (int i = 0; i < 3; i++)
            r[i] = m[i][0]*v[0] + m[i][1]*v[1] + m[i][2]*v[2];
        if (r[0] == 0 && r[1] == 0 && r[2] == 0)
        begin
            u = '0;
            u.zl = 1'b1;
            return u;
        end
        a = 0;
        for (int i = 0; i < 3; i++)
        begin
            c[i] = r[i] < 0 ? -r[i] : r[i];
            if (c[i] > a)
                a = c[i];
        end
        s = 0;
        while ((a >> s) >= (64'd1 << 31))
            s++;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            c[i] >>= s;
            sum += c[i] * c[i];
        end
        len = int_sqrt(sum);
        if (len == 0)
            len = 1;
        for (int i = 0; i < 3; i++)
        begin
            q = (c[i] * 64'd16384 + len / 2) / len;
            if (q > 16384)
                q = 16384;
            o[i] = r[i] < 0 ? -16'(q) : 16'(q);
        end
        u.x = o[0]; u.y = o[1]; u.z = o[2]; u.zl = 1'b0;
        return u;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        unit_vec_t e;
        if (!rst_n)
        begin
            q_w <= 16'sd16384;
            q_x <= '0;
            q_y <= '0;
            q_z <= '0;
            fail_count = 0;
            unit_queue.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    qvr_pkg::REG_QUAT_W: q_w <= cfg_data;
                    qvr_pkg::REG_QUAT_X: q_x <= cfg_data;
                    qvr_pkg::REG_QUAT_Y: q_y <= cfg_data;
                    qvr_pkg::REG_QUAT_Z: q_z <= cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                unit_queue.push_back(rotate_unit(vec_x, vec_y, vec_z));
            if (out_valid && out_ready)
            begin
                if (unit_queue.size() == 0)
                    report_mismatch("unexpected result", out_x, 0);
                else
                begin
                    e = unit_queue.pop_front();
                    if (out_x !== e.x)
                        report_mismatch("out_x", out_x, e.x);
                    if (out_y !== e.y)
                        report_mismatch("out_y", out_y, e.y);
                    if (out_z !== e.z)
                        report_mismatch("out_z", out_z, e.z);
                    if (zero_length !== e.zl)
                        report_mismatch("zero_length", zero_length, e.zl);
                end
            end
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives quaternion settings and vector requests, randomly idling requests and
// results; the checker predicts and compares every unit vector result.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LATENCY   = 59;
    localparam int MAX_CYCLE = 400000;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  cfg_valid;
    logic                                  cfg_ready;
    logic [qvr_pkg::CFG_IDX_W-1:0]         cfg_index;
    logic [qvr_pkg::Q_W-1:0]               cfg_data;
    logic                                  in_valid;
    logic                                  in_ready;
    logic signed [qvr_pkg::Q_W-1:0]        vec_x, vec_y, vec_z;
    logic                                  out_valid;
    logic                                  out_ready;
    logic signed [qvr_pkg::Q_W-1:0]        out_x, out_y, out_z;
    logic                                  zero_length;
    int                                    fail_count;
    int                                    pending;
    int                                    cycle;
    int                                    idle_pct;

    quaternion_vector_rotate_core i_dut (.*);

    qvr_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle = 0;
        forever
        begin
            @(posedge clk);
            cycle++;
            if (cycle > MAX_CYCLE)
            begin
                $display("timeout");
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // result side stalls
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= idle_pct);

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input logic [qvr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_quat(input logic [15:0] w, input logic [15:0] x,
                            input logic [15:0] y, input logic [15:0] z);
        write_reg(qvr_pkg::REG_QUAT_W, w);
        write_reg(qvr_pkg::REG_QUAT_X, x);
        write_reg(qvr_pkg::REG_QUAT_Y, y);
        write_reg(qvr_pkg::REG_QUAT_Z, z);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    task automatic send_vec(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] z);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        vec_x <= x;
        vec_y <= y;
        vec_z <= z;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($urandom_range(15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [15:0] w, x, y, z;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        vec_x     = '0;
        vec_y     = '0;
        vec_z     = '0;
        out_ready = 1'b0;
        idle_pct  = 21;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // identity quaternion after reset: extremes, zero vector, small values
        send_vec(16'h0000, 16'h0000, 16'h0000);
        send_vec(16'h7fff, 16'h0000, 16'h0000);
        send_vec(16'h8000, 16'h8000, 16'h8000);
        send_vec(16'h7fff, 16'h7fff, 16'h7fff);
        send_vec(16'h0001, 16'hffff, 16'h0000);
        send_vec(16'h8000, 16'h7fff, 16'h0001);
        in_valid <= 1'b0;
        drain();
        // 90 degrees about z
        set_quat(16'd11585, 16'd0, 16'd0, 16'd11585);
        send_vec(16'd100, 16'd0, 16'd0);
        send_vec(16'h8000, 16'h7fff, 16'h8000);
        send_vec(16'd0, 16'd0, 16'd5);
        in_valid <= 1'b0;
        drain();
        // degenerate and extreme quaternions
        set_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_vec(16'd3, 16'd4, 16'd5);
        in_valid <= 1'b0;
        drain();
        set_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_vec(16'h7fff, 16'h8000, 16'h0001);
        send_vec(16'd1, 16'd1, 16'd1);
        in_valid <= 1'b0;
        drain();
        set_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_vec(16'h8000, 16'h8000, 16'h7fff);
        send_vec(16'd0, 16'd0, 16'd0);
        in_valid <= 1'b0;
        drain();
        // out-of-range index is ignored
        write_reg(8'd200, 16'h1234);
        set_quat(16'd0, 16'd16384, 16'd0, 16'd0);
        send_vec(16'd7, 16'hfff0, 16'd9);
        in_valid <= 1'b0;
        drain();

        for (int ph = 0; ph < 12; ph++)
        begin
            // one phase runs flat out to push the pipeline hard
            idle_pct = (ph == 3) ? 0 : 21;
            case (ph % 3)
                0:
                begin
                    // random quaternion, each component from -16384 to 16383
                    w = 16'($urandom_range(32767)) - 16'd16384;
                    x = 16'($urandom_range(32767)) - 16'd16384;
                    y = 16'($urandom_range(32767)) - 16'd16384;
                    z = 16'($urandom_range(32767)) - 16'd16384;
                end
                default:
                begin
                    w = rand_comp(); x = rand_comp(); y = rand_comp(); z = rand_comp();
                end
            endcase
            set_quat(w, x, y, z);
            for (int n = 0; n < 95; n++)
                send_vec(rand_comp(), rand_comp(), rand_comp());
            in_valid <= 1'b0;
            drain();
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/qvr_pkg.sv
rtl/core/qvr_rotate.sv
rtl/core/qvr_scale.sv
rtl/core/qvr_sqrt.sv
rtl/core/qvr_div.sv
rtl/core/quaternion_vector_rotate_core.sv
bench/qvr_checker.sv
bench/tb_top.sv
